FILE: rtl/bsf_pkg.sv
// shared constants and status type for the byte stream fifo
package bsf_pkg;

  localparam int CMD_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 6;
  localparam int LEVEL_W   = 11;
  localparam int TOTAL_W   = 64;
  localparam int BURST_W   = 7;

  localparam int DEF_STORE_DEPTH = 1024;
  localparam int DEF_MAX_BURST   = 32;

  localparam logic [LEVEL_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_END   = 3'd4;

  typedef struct packed {
    logic [LEVEL_W-1:0] fill_level;
    logic [LEVEL_W-1:0] free_space;
    logic               ended;
    logic               at_eof;
    logic [TOTAL_W-1:0] total_written;
    logic [TOTAL_W-1:0] total_read;
  } status_t;

endpackage

FILE: rtl/byte_stream_fifo_unit.sv
// byte stream fifo top level: capacity register, sequencer and byte store
//
// Input channel (in_valid / in_stall): one command per item - write a byte,
// read, peek or pop up to in_count bytes, or mark end of input.
// Result channel (out_valid / out_stall): every result carries the fill
// level, free space, ended and eof flags and both 64-bit byte totals, all
// showing the state after the whole command.
// Write, pop, end and empty read or peek give one status result; read and
// peek give one result per delivered byte, the final one flagged out_last.
// Throughput: single-result commands run at one item per cycle unless the
// result side stalls, result in the cycle after acceptance. A read or peek
// goes through the byte store read port one byte a cycle unless stalled.
// A stall on the result side holds the result register and backpressures
// the input; the store read is held back so no byte is lost.
// cfg_data sets the capacity limit; write it only while the block is idle.
// Reset (rst_n low, synchronous) empties the fifo, clears the totals and the
// ended flag and sets the limit to 1024; the store contents are left as is.
module byte_stream_fifo_unit #(
  parameter int STORE_DEPTH = bsf_pkg::DEF_STORE_DEPTH,
  parameter int MAX_BURST   = bsf_pkg::DEF_MAX_BURST
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsf_pkg::LEVEL_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bsf_pkg::CMD_W-1:0]     in_command,
  input  logic [bsf_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic [bsf_pkg::COUNT_W-1:0]   in_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bsf_pkg::BYTE_W-1:0]    out_out_byte,
  output logic                          out_byte_valid,
  output logic                          out_last,
  output logic                          out_accepted,
  output logic [bsf_pkg::LEVEL_W-1:0]   out_fill_level,
  output logic [bsf_pkg::LEVEL_W-1:0]   out_free_space,
  output logic                          out_ended,
  output logic                          out_at_eof,
  output logic [bsf_pkg::TOTAL_W-1:0]   out_total_written,
  output logic [bsf_pkg::TOTAL_W-1:0]   out_total_read
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [bsf_pkg::LEVEL_W-1:0] cap_r;
  bsf_pkg::status_t            status;
  logic                        mem_wr_en;
  logic [AW-1:0]               mem_wr_addr;
  logic [bsf_pkg::BYTE_W-1:0]  mem_wr_data;
  logic                        mem_rd_en;
  logic [AW-1:0]               mem_rd_addr;
  logic [bsf_pkg::BYTE_W-1:0]  mem_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bsf_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  bsf_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_BURST   (MAX_BURST),
    .AW          (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cap            (cap_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_data_byte   (in_data_byte),
    .in_count       (in_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_accepted   (out_accepted),
    .status         (status),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  bsf_mem #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign out_fill_level    = status.fill_level;
  assign out_free_space    = status.free_space;
  assign out_ended         = status.ended;
  assign out_at_eof        = status.at_eof;
  assign out_total_written = status.total_written;
  assign out_total_read    = status.total_read;

endmodule

FILE: rtl/bsf_mem.sv
// byte store: one write port, one read port with registered read data
module bsf_mem #(
  parameter int DEPTH = bsf_pkg::DEF_STORE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bsf_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [bsf_pkg::BYTE_W-1:0] rd_data
);

  logic [bsf_pkg::BYTE_W-1:0] store_r [DEPTH];
  logic [bsf_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/bsf_ctrl.sv
// command sequencer, pointers, counters and result register
module bsf_ctrl #(
  parameter int STORE_DEPTH = bsf_pkg::DEF_STORE_DEPTH,
  parameter int MAX_BURST   = bsf_pkg::DEF_MAX_BURST,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bsf_pkg::LEVEL_W-1:0]   cap,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bsf_pkg::CMD_W-1:0]     in_command,
  input  logic [bsf_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic [bsf_pkg::COUNT_W-1:0]   in_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bsf_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_byte_valid,
  output logic                          out_last,
  output logic                          out_accepted,
  output bsf_pkg::status_t              status,
  output logic                          mem_wr_en,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic [bsf_pkg::BYTE_W-1:0]    mem_wr_data,
  output logic                          mem_rd_en,
  output logic [AW-1:0]                 mem_rd_addr,
  input  logic [bsf_pkg::BYTE_W-1:0]    mem_rd_data
);

  localparam int LW = bsf_pkg::LEVEL_W;
  localparam int BW = bsf_pkg::BURST_W;
  localparam int TW = bsf_pkg::TOTAL_W;
  localparam int SW = AW + BW + 1;

  typedef enum logic {ST_IDLE, ST_BURST} state_t;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              head_r, head_nxt;
  logic [AW-1:0]              tail_r, tail_nxt;
  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic [LW-1:0]              held_r, held_nxt;
  logic [TW-1:0]              wtot_r, wtot_nxt;
  logic [TW-1:0]              rtot_r, rtot_nxt;
  logic                       ended_r, ended_nxt;
  logic [BW-1:0]              rem_r, rem_nxt;
  logic                       pend_r, pend_nxt;
  logic                       pend_last_r, pend_last_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [bsf_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                       bvalid_r, bvalid_nxt;
  logic                       last_r, last_nxt;
  logic                       acc_r, acc_nxt;

  logic                       out_free;
  logic                       in_acc;
  logic                       take;
  logic [LW-1:0]              eff_cap;
  logic [LW-1:0]              cnt_ext;
  logic [LW-1:0]              n_lvl;
  logic [BW-1:0]              n_b;

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [BW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(k);
    if (s >= SW'(STORE_DEPTH)) begin
      s = s - SW'(STORE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign take     = pend_r && out_free;

  // a limit above the store depth acts as the depth
  assign eff_cap = ({21'b0, cap} > 32'(STORE_DEPTH)) ? LW'(STORE_DEPTH) : cap;

  assign cnt_ext = LW'(in_count);
  assign n_lvl   = (held_r < cnt_ext) ? held_r : cnt_ext;
  assign n_b     = (n_lvl > LW'(MAX_BURST)) ? BW'(MAX_BURST) : n_lvl[BW-1:0];

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    ptr_nxt       = ptr_r;
    held_nxt      = held_r;
    wtot_nxt      = wtot_r;
    rtot_nxt      = rtot_r;
    ended_nxt     = ended_r;
    rem_nxt       = rem_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    bvalid_nxt    = bvalid_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = tail_r;
    mem_wr_data   = in_data_byte;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = ptr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // status result unless a burst starts below
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          bvalid_nxt    = 1'b0;
          last_nxt      = 1'b1;
          acc_nxt       = 1'b0;
          case (in_command)
            bsf_pkg::CMD_WRITE: begin
              if (held_r < eff_cap) begin
                mem_wr_en = 1'b1;
                tail_nxt  = ptr_add(tail_r, BW'(1));
                held_nxt  = held_r + LW'(1);
                wtot_nxt  = wtot_r + TW'(1);
                acc_nxt   = 1'b1;
              end
            end
            bsf_pkg::CMD_READ, bsf_pkg::CMD_PEEK: begin
              if (n_b != '0) begin
                out_valid_nxt = 1'b0;
                mem_rd_en     = 1'b1;
                mem_rd_addr   = head_r;
                ptr_nxt       = ptr_add(head_r, BW'(1));
                rem_nxt       = n_b - BW'(1);
                pend_nxt      = 1'b1;
                pend_last_nxt = (n_b == BW'(1));
                state_nxt     = ST_BURST;
                if (in_command == bsf_pkg::CMD_READ) begin
                  head_nxt = ptr_add(head_r, n_b);
                  held_nxt = held_r - LW'(n_b);
                  rtot_nxt = rtot_r + TW'(n_b);
                end
              end
            end
            bsf_pkg::CMD_POP: begin
              head_nxt = ptr_add(head_r, n_b);
              held_nxt = held_r - LW'(n_b);
              rtot_nxt = rtot_r + TW'(n_b);
            end
            bsf_pkg::CMD_END: begin
              ended_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BURST: begin
        if (take) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = mem_rd_data;
          bvalid_nxt    = 1'b1;
          last_nxt      = pend_last_r;
          acc_nxt       = 1'b0;
          pend_nxt      = 1'b0;
        end
        // next read only once the held byte has moved on
        if ((rem_r != '0) && (!pend_r || take)) begin
          mem_rd_en     = 1'b1;
          mem_rd_addr   = ptr_r;
          ptr_nxt       = ptr_add(ptr_r, BW'(1));
          rem_nxt       = rem_r - BW'(1);
          pend_nxt      = 1'b1;
          pend_last_nxt = (rem_r == BW'(1));
        end
        if (take && (rem_r == '0)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      ptr_r       <= '0;
      held_r      <= '0;
      wtot_r      <= '0;
      rtot_r      <= '0;
      ended_r     <= 1'b0;
      rem_r       <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      ptr_r       <= ptr_nxt;
      held_r      <= held_nxt;
      wtot_r      <= wtot_nxt;
      rtot_r      <= rtot_nxt;
      ended_r     <= ended_nxt;
      rem_r       <= rem_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r <= out_byte_nxt;
    bvalid_r   <= bvalid_nxt;
    last_r     <= last_nxt;
    acc_r      <= acc_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = bvalid_r;
  assign out_last       = last_r;
  assign out_accepted   = acc_r;

  // state is committed at accept, so these already show the after-step values
  assign status.fill_level    = held_r;
  assign status.free_space    = (eff_cap > held_r) ? (eff_cap - held_r) : '0;
  assign status.ended         = ended_r;
  assign status.at_eof        = ended_r && (held_r == '0);
  assign status.total_written = wtot_r;
  assign status.total_read    = rtot_r;

endmodule

FILE: verif/tb_byte_stream_fifo_unit.sv
// testbench for byte_stream_fifo_unit: directed rows, then random phases checked by a predictor
`timescale 1ns / 100ps

module tb_byte_stream_fifo_unit;

  localparam int CMD_W = bsf_pkg::CMD_W;
  localparam int BYTE_W = bsf_pkg::BYTE_W;
  localparam int COUNT_W = bsf_pkg::COUNT_W;
  localparam int LEVEL_W = bsf_pkg::LEVEL_W;
  localparam int TOTAL_W = bsf_pkg::TOTAL_W;
  localparam int HALF_PERIOD = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int FIFO_DEPTH = bsf_pkg::DEF_STORE_DEPTH;
  localparam int BURST_MAX = bsf_pkg::DEF_MAX_BURST;
  localparam int MEM_AW = $clog2(FIFO_DEPTH);
  localparam int BURST_AW = $clog2(BURST_MAX);
  localparam int HOLD_AFTER = 120;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_PHASES = 7;
  localparam int PHASE_ITEMS = 52;
  localparam int NUM_ROWS = 19;
  localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              bvalid;
    logic              is_last;
    logic              acc;
    bsf_pkg::status_t  st;
  } fifo_result_t;

  // typed == 1 means the acc flag and status below are the expectation for that single-result row
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BYTE_W-1:0]  data;
    logic [COUNT_W-1:0] cnt;
    logic               typed;
    logic               acc;
    logic [LEVEL_W-1:0] fill;
    logic [LEVEL_W-1:0] space;
    logic               ended;
    logic               eof;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LEVEL_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_command = bsf_pkg::CMD_WRITE;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic [COUNT_W-1:0] in_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [BYTE_W-1:0] out_out_byte;
  logic out_byte_valid;
  logic out_last;
  logic out_accepted;
  logic [LEVEL_W-1:0] out_fill_level;
  logic [LEVEL_W-1:0] out_free_space;
  logic out_ended;
  logic out_at_eof;
  logic [TOTAL_W-1:0] out_total_written;
  logic [TOTAL_W-1:0] out_total_read;

  // predictor state
  logic [BYTE_W-1:0] model_mem [FIFO_DEPTH];
  int unsigned model_head = 0;
  int unsigned model_held = 0;
  logic [TOTAL_W-1:0] model_wr_total = '0;
  logic [TOTAL_W-1:0] model_rd_total = '0;
  logic model_ended = 1'b0;
  int unsigned model_cap = 32'(bsf_pkg::CAP_RESET);

  fifo_result_t pending_results[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit held_off = 1'b0;

  byte_stream_fifo_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_data_byte      (in_data_byte),
    .in_count          (in_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_out_byte      (out_out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_last          (out_last),
    .out_accepted      (out_accepted),
    .out_fill_level    (out_fill_level),
    .out_free_space    (out_free_space),
    .out_ended         (out_ended),
    .out_at_eof        (out_at_eof),
    .out_total_written (out_total_written),
    .out_total_read    (out_total_read)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int unsigned usable_capacity();
    return (model_cap > FIFO_DEPTH) ? FIFO_DEPTH : model_cap;
  endfunction

  function automatic void queue_result(logic [BYTE_W-1:0] data, logic bvalid, logic is_last,
                                       logic acc);
    fifo_result_t r;
    int unsigned cap;
    cap = usable_capacity();
    r.data = data;
    r.bvalid = bvalid;
    r.is_last = is_last;
    r.acc = acc;
    r.st.fill_level = LEVEL_W'(model_held);
    r.st.free_space = (cap > model_held) ? LEVEL_W'(cap - model_held) : '0;
    r.st.ended = model_ended;
    r.st.at_eof = model_ended && (model_held == 0);
    r.st.total_written = model_wr_total;
    r.st.total_read = model_rd_total;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void predict_fifo_results(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                               logic [COUNT_W-1:0] cnt);
    int unsigned n;
    logic [BYTE_W-1:0] got [BURST_MAX];
    n = 32'(cnt);
    if (n > model_held) n = model_held;
    if (n > BURST_MAX) n = BURST_MAX;
    case (cmd)
      bsf_pkg::CMD_WRITE: begin
        if (model_held < usable_capacity()) begin
          model_mem[MEM_AW'((model_head + model_held) % FIFO_DEPTH)] = data;
          model_held++;
          model_wr_total++;
          queue_result('0, 1'b0, 1'b1, 1'b1);
        end else begin
          queue_result('0, 1'b0, 1'b1, 1'b0);
        end
      end
      bsf_pkg::CMD_READ, bsf_pkg::CMD_PEEK: begin
        for (int i = 0; i < n; i++)
          got[BURST_AW'(i)] = model_mem[MEM_AW'((model_head + i) % FIFO_DEPTH)];
        if (cmd == bsf_pkg::CMD_READ) begin
          model_head = (model_head + n) % FIFO_DEPTH;
          model_held -= n;
          model_rd_total += TOTAL_W'(n);
        end
        if (n == 0) queue_result('0, 1'b0, 1'b1, 1'b0);
        for (int i = 0; i < n; i++) queue_result(got[BURST_AW'(i)], 1'b1, (i + 1 == n), 1'b0);
      end
      bsf_pkg::CMD_POP: begin
        model_head = (model_head + n) % FIFO_DEPTH;
        model_held -= n;
        model_rd_total += TOTAL_W'(n);
        queue_result('0, 1'b0, 1'b1, 1'b0);
      end
      bsf_pkg::CMD_END: begin
        model_ended = 1'b1;
        queue_result('0, 1'b0, 1'b1, 1'b0);
      end
      default: queue_result('0, 1'b0, 1'b1, 1'b0);
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [TOTAL_W-1:0] got,
                                 logic [TOTAL_W-1:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $time);
    mismatch_count++;
  endtask

  // result checker
  initial begin
    fifo_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item", TOTAL_W'({out_fill_level, out_out_byte}), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_out_byte !== want.data)
            report_mismatch("out_byte", TOTAL_W'(out_out_byte), TOTAL_W'(want.data));
          if (out_byte_valid !== want.bvalid)
            report_mismatch("byte_valid", TOTAL_W'(out_byte_valid), TOTAL_W'(want.bvalid));
          if (out_last !== want.is_last)
            report_mismatch("last", TOTAL_W'(out_last), TOTAL_W'(want.is_last));
          if (out_accepted !== want.acc)
            report_mismatch("accepted", TOTAL_W'(out_accepted), TOTAL_W'(want.acc));
          if (out_fill_level !== want.st.fill_level)
            report_mismatch("fill_level", TOTAL_W'(out_fill_level),
                            TOTAL_W'(want.st.fill_level));
          if (out_free_space !== want.st.free_space)
            report_mismatch("free_space", TOTAL_W'(out_free_space),
                            TOTAL_W'(want.st.free_space));
          if (out_ended !== want.st.ended)
            report_mismatch("ended", TOTAL_W'(out_ended), TOTAL_W'(want.st.ended));
          if (out_at_eof !== want.st.at_eof)
            report_mismatch("at_eof", TOTAL_W'(out_at_eof), TOTAL_W'(want.st.at_eof));
          if (out_total_written !== want.st.total_written)
            report_mismatch("total_written", out_total_written, want.st.total_written);
          if (out_total_read !== want.st.total_read)
            report_mismatch("total_read", out_total_read, want.st.total_read);
        end
      end
    end
  end

  // receiver side: random stall bursts, one long hold so the block backs up
  initial begin
    int stall_len;
    forever begin
      @(negedge clk);
      if (!held_off && items_sent >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_len = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (stall_len - 1) @(negedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b0;
        repeat (20) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic sender_gap();
    int gap_len;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap_len = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap_len - 1) @(negedge clk);
    end
  endtask

  task automatic issue_cmd(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                           logic [COUNT_W-1:0] cnt);
    @(negedge clk);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_data_byte <= data;
    in_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    predict_fifo_results(cmd, data, cnt);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [LEVEL_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_cap = 32'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    dir_row_t dir_rows [NUM_ROWS];
    // phases: limit zero, oversized limit, limits below the fill level, small limits
    logic [LEVEL_W-1:0] phase_cap [NUM_PHASES];
    int phase_wr_pct [NUM_PHASES];
    int phase_prefill [NUM_PHASES];
    fifo_result_t row_exp;
    logic [CMD_W-1:0] cmd;
    logic [COUNT_W-1:0] cnt;
    int pick;

    dir_rows = '{
      '{bsf_pkg::CMD_READ,  8'h00, 6'd5,  1'b1, 1'b0, 11'd0, 11'd1024, 1'b0, 1'b0},
      '{bsf_pkg::CMD_PEEK,  8'hFF, 6'd63, 1'b1, 1'b0, 11'd0, 11'd1024, 1'b0, 1'b0},
      '{bsf_pkg::CMD_POP,   8'h00, 6'd63, 1'b1, 1'b0, 11'd0, 11'd1024, 1'b0, 1'b0},
      '{bsf_pkg::CMD_WRITE, 8'h00, 6'd0,  1'b1, 1'b1, 11'd1, 11'd1023, 1'b0, 1'b0},
      '{bsf_pkg::CMD_WRITE, 8'hFF, 6'd63, 1'b1, 1'b1, 11'd2, 11'd1022, 1'b0, 1'b0},
      '{bsf_pkg::CMD_WRITE, 8'hA5, 6'd0,  1'b1, 1'b1, 11'd3, 11'd1021, 1'b0, 1'b0},
      '{bsf_pkg::CMD_WRITE, 8'h5A, 6'd0,  1'b1, 1'b1, 11'd4, 11'd1020, 1'b0, 1'b0},
      '{bsf_pkg::CMD_PEEK,  8'h00, 6'd2,  1'b0, 1'b0, 11'd0, 11'd0,    1'b0, 1'b0},
      '{bsf_pkg::CMD_READ,  8'h00, 6'd0,  1'b1, 1'b0, 11'd4, 11'd1020, 1'b0, 1'b0},
      '{bsf_pkg::CMD_READ,  8'h00, 6'd1,  1'b0, 1'b0, 11'd0, 11'd0,    1'b0, 1'b0},
      '{bsf_pkg::CMD_POP,   8'h00, 6'd1,  1'b1, 1'b0, 11'd2, 11'd1022, 1'b0, 1'b0},
      '{CMD_BAD_LO,         8'hFF, 6'd0,  1'b1, 1'b0, 11'd2, 11'd1022, 1'b0, 1'b0},
      '{CMD_BAD_HI,         8'h00, 6'd63, 1'b1, 1'b0, 11'd2, 11'd1022, 1'b0, 1'b0},
      '{bsf_pkg::CMD_END,   8'h00, 6'd0,  1'b1, 1'b0, 11'd2, 11'd1022, 1'b1, 1'b0},
      // end does not block writes
      '{bsf_pkg::CMD_WRITE, 8'h3C, 6'd0,  1'b1, 1'b1, 11'd3, 11'd1021, 1'b1, 1'b0},
      '{bsf_pkg::CMD_READ,  8'h00, 6'd63, 1'b0, 1'b0, 11'd0, 11'd0,    1'b0, 1'b0},
      '{bsf_pkg::CMD_READ,  8'h00, 6'd32, 1'b1, 1'b0, 11'd0, 11'd1024, 1'b1, 1'b1},
      '{bsf_pkg::CMD_WRITE, 8'h81, 6'd32, 1'b1, 1'b1, 11'd1, 11'd1023, 1'b1, 1'b0},
      '{bsf_pkg::CMD_PEEK,  8'h00, 6'd63, 1'b0, 1'b0, 11'd0, 11'd0,    1'b0, 1'b0}
    };
    phase_cap = '{11'd0, 11'd2047, 11'd5, 11'd1, 11'd1024, 11'd40, 11'd3};
    phase_wr_pct = '{50, 70, 55, 50, 60, 50, 50};
    phase_prefill = '{0, 40, 0, 0, 0, 0, 0};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      sender_gap();
      issue_cmd(dir_rows[r].cmd, dir_rows[r].data, dir_rows[r].cnt);
      if (dir_rows[r].typed) begin
        row_exp = pending_results[pending_results.size() - 1];
        row_exp.acc = dir_rows[r].acc;
        row_exp.st.fill_level = dir_rows[r].fill;
        row_exp.st.free_space = dir_rows[r].space;
        row_exp.st.ended = dir_rows[r].ended;
        row_exp.st.at_eof = dir_rows[r].eof;
        pending_results[pending_results.size() - 1] = row_exp;
      end
    end

    foreach (phase_cap[p]) begin
      drain_results();
      write_capacity(phase_cap[p]);
      calm = (p == NUM_PHASES - 1);
      for (int k = 0; k < phase_prefill[p]; k++) begin
        sender_gap();
        issue_cmd(bsf_pkg::CMD_WRITE, BYTE_W'($urandom_range(0, 255)), '0);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < phase_wr_pct[p]) begin
          cmd = bsf_pkg::CMD_WRITE;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 40) cmd = bsf_pkg::CMD_READ;
          else if (pick < 60) cmd = bsf_pkg::CMD_PEEK;
          else if (pick < 80) cmd = bsf_pkg::CMD_POP;
          else if (pick < 88) cmd = bsf_pkg::CMD_END;
          // unknown command codes, spread over the whole unused range
          else cmd = CMD_W'($urandom_range(32'(CMD_BAD_LO), 32'(CMD_BAD_HI)));
        end
        // mostly short counts, now and then the whole field
        if ($urandom_range(0, 4) == 0) cnt = COUNT_W'($urandom_range(0, 63));
        else cnt = COUNT_W'($urandom_range(0, 6));
        sender_gap();
        issue_cmd(cmd, BYTE_W'($urandom_range(0, 255)), cnt);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
